// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/wco_pkg.sv -----
// Types and constants for the wavetable cubic oscillator.
package wco_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int SIZE_W      = 13;
  localparam int SAMPLE_W    = 16;
  localparam int PHASE_W     = 32;
  localparam int GAIN_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = PHASE_W + SIZE_W;

  // Datapath widths of the Hermite evaluation
  localparam int S0_W = 17;
  localparam int CA_W = 20;
  localparam int CB_W = 21;
  localparam int AF_W = CA_W + 17;
  localparam int X1_W = 38;
  localparam int X2_W = 39;
  localparam int X3_W = 40;
  localparam int M_W  = 41;
  localparam int PL_W = M_W + 17;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_RIGHT  = 3'd5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;

endpackage

// ----- hdl/wco_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wco_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/wavetable_cubic_oscillator_core.sv -----
// Wavetable oscillator voice with 4-point cubic Hermite interpolation and stereo pan.
//
// Input channel (in_valid/in_ready): in_mode 0 writes in_table_value to sample
// entry in_table_address and returns nothing; in_mode 1 is a sample tick that
// returns one stereo item on the output channel (out_valid/out_ready).
// Config port: cfg_we writes cfg_data to register cfg_index; write
// only while no tick is in flight. Unknown indexes are ignored.
// Table writes are taken one per cycle while the block is idle. An audible tick
// runs the phase multiply and the address step, then four serial reads through
// the one read port of the sample memory plus a chain of five registered multiply
// steps, and then delivers its result; no new item is taken while a tick is in
// flight. A silent tick (size 0, gain 0 or increment below minimum) gives zeros
// and skips the reads and multiplies.
// The output register holds a finished item while the receiver stalls; the
// block still accepts the next item, and a later tick waits in its last step
// until the register frees.
// Reset (synchronous) clears the configuration registers, phase and handshake
// state; the sample memory is not cleared and entries are undefined until written.
module wavetable_cubic_oscillator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wco_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [wco_pkg::ADDR_W-1:0]        in_table_address,
  input  logic signed [wco_pkg::SAMPLE_W-1:0] in_table_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wco_pkg::SAMPLE_W-1:0] out_left_sample,
  output logic signed [wco_pkg::SAMPLE_W-1:0] out_right_sample
);

  import wco_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADDR, S_READ, S_COEF, S_X1, S_X2, S_X3, S_GAIN, S_PAN, S_OUT
  } state_t;

  localparam logic [2:0] READ_LAST = 3'd4;
  localparam logic signed [PL_W-1:0] ROUND_HALF = PL_W'(64'sh80000000);

  // Configuration
  logic [PHASE_W-1:0] phase_inc_r, min_inc_r;
  logic [SIZE_W-1:0]  table_size_r;
  logic [GAIN_W-1:0]  voice_gain_r, pan_left_r, pan_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r  <= '0;
      min_inc_r    <= '0;
      table_size_r <= '0;
      voice_gain_r <= '0;
      pan_left_r   <= '0;
      pan_right_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_INC:  phase_inc_r  <= cfg_data[PHASE_W-1:0];
        REG_MIN_INC:    min_inc_r    <= cfg_data[PHASE_W-1:0];
        REG_TABLE_SIZE: table_size_r <= cfg_data[SIZE_W-1:0];
        REG_VOICE_GAIN: voice_gain_r <= cfg_data[GAIN_W-1:0];
        REG_PAN_LEFT:   pan_left_r   <= cfg_data[GAIN_W-1:0];
        REG_PAN_RIGHT:  pan_right_r  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  state_t             state_r, state_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_left_r, out_left_nxt, out_right_r, out_right_nxt;

  // Datapath registers
  logic [PROD_W-1:0]      prod_r;
  addr_t                  addr_r [4];
  logic [15:0]            f_r;
  sample_t                v_r [4];
  logic signed [S0_W-1:0] s0_r;
  logic signed [CA_W-1:0] ca_r;
  logic signed [CB_W-1:0] cb_r;
  logic signed [X1_W-1:0] x1_r;
  logic signed [X2_W-1:0] x2_r;
  logic signed [X3_W-1:0] x3_r;
  logic signed [M_W-1:0]  m_r;
  sample_t                res_left_r, res_right_r;

  logic [SIZE_W-1:0] size_eff;
  logic              silent;
  logic              in_acc;
  logic              ram_we;
  sample_t           rd_data;
  addr_t             raddr;

  assign size_eff = (table_size_r > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : table_size_r;
  assign silent   = (size_eff == '0) || (voice_gain_r == '0) || (phase_inc_r < min_inc_r);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ram_we   = in_acc && (in_mode == MODE_WRITE);
  assign raddr    = addr_r[cnt_r[1:0]];

  // Sample store; writes happen only in idle, read data is used only during a tick
  wco_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_wave_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (in_table_address),
    .wdata   (in_table_value),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_TICK)) begin
          state_nxt = silent ? S_OUT : S_MUL;
        end
      end
      S_MUL: begin
        phase_nxt = phase_r + phase_inc_r;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cnt_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == READ_LAST) begin
          state_nxt = S_COEF;
        end
      end
      S_COEF: state_nxt = S_X1;
      S_X1:   state_nxt = S_X2;
      S_X2:   state_nxt = S_X3;
      S_X3:   state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_PAN;
      S_PAN:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = res_left_r;
          out_right_nxt = res_right_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      out_left_r  <= '0;
      out_right_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      out_left_r  <= out_left_nxt;
      out_right_r <= out_right_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

  // Neighbor addresses, wrapped to the table size
  addr_t             idx_c, i0_c;
  logic [SIZE_W-1:0] inc1_c, i2_c, inc2_c, i3_c;

  always_comb begin
    idx_c  = prod_r[PHASE_W+ADDR_W-1:PHASE_W];
    i0_c   = (idx_c == '0) ? ADDR_W'(size_eff - SIZE_W'(1)) : idx_c - ADDR_W'(1);
    inc1_c = {1'b0, idx_c} + SIZE_W'(1);
    i2_c   = (inc1_c == size_eff) ? '0 : inc1_c;
    inc2_c = i2_c + SIZE_W'(1);
    i3_c   = (inc2_c == size_eff) ? '0 : inc2_c;
  end

  // Hermite coefficients (slopes kept doubled)
  logic signed [S0_W-1:0] s0_c, s1_c, dh_c;
  logic signed [S0_W:0]   d_c;
  logic signed [S0_W+1:0] ss_c;
  logic signed [CA_W-1:0] ca_c;
  logic signed [CB_W-1:0] cb_c;

  always_comb begin
    s0_c = S0_W'(v_r[2]) - S0_W'(v_r[0]);
    s1_c = S0_W'(v_r[3]) - S0_W'(v_r[1]);
    dh_c = S0_W'(v_r[1]) - S0_W'(v_r[2]);
    d_c  = (S0_W+1)'(dh_c) <<< 1;
    ss_c = (S0_W+2)'(s0_c) + (S0_W+2)'(d_c);
    ca_c = CA_W'(ss_c) + CA_W'(d_c) + CA_W'(s1_c);
    cb_c = CB_W'(ss_c) + CB_W'(ca_c);
  end

  // Multiply chain
  logic signed [16:0]       f_s, gain_s, panl_s, panr_s;
  logic signed [AF_W-1:0]   af_c;
  logic signed [X1_W+16:0]  xf1_c;
  logic signed [X2_W+16:0]  xf2_c;
  logic signed [X3_W+16:0]  xg_c;
  logic signed [PL_W-1:0]   ml_c, mr_c, pl_c, pr_c;
  logic signed [X1_W-1:0]   x1_c;
  logic signed [X2_W-1:0]   x2_c;
  logic signed [X3_W-1:0]   x3_c;
  logic signed [M_W-1:0]    m_c;

  assign f_s    = $signed({1'b0, f_r});
  assign gain_s = $signed({1'b0, voice_gain_r});
  assign panl_s = $signed({1'b0, pan_left_r});
  assign panr_s = $signed({1'b0, pan_right_r});

  assign af_c  = ca_r * f_s;
  assign xf1_c = x1_r * f_s;
  assign xf2_c = x2_r * f_s;
  assign xg_c  = x3_r * gain_s;
  assign ml_c  = m_r * panl_s;
  assign mr_c  = m_r * panr_s;

  assign x1_c = X1_W'(af_c) - (X1_W'(cb_r) <<< 16);
  assign x2_c = X2_W'(xf1_c >>> 16) + (X2_W'(s0_r) <<< 16);
  assign x3_c = X3_W'(xf2_c >>> 16) + (X3_W'(v_r[1]) <<< 17);
  assign m_c  = M_W'(xg_c >>> 15);
  assign pl_c = ml_c + ROUND_HALF;
  assign pr_c = mr_c + ROUND_HALF;

  function automatic sample_t sat16(input logic signed [PL_W-33:0] v);
    sample_t r;
    if (v > (PL_W-32)'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -(PL_W-32)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_TICK) && silent) begin
          res_left_r  <= '0;
          res_right_r <= '0;
        end
      end
      S_MUL: prod_r <= phase_r * size_eff;
      S_ADDR: begin
        addr_r[0] <= i0_c;
        addr_r[1] <= idx_c;
        addr_r[2] <= i2_c[ADDR_W-1:0];
        addr_r[3] <= i3_c[ADDR_W-1:0];
        f_r       <= prod_r[PHASE_W-1:PHASE_W-16];
      end
      S_READ: begin
        if (cnt_r != '0) begin
          v_r[2'(cnt_r[1:0] - 2'd1)] <= rd_data;
        end
      end
      S_COEF: begin
        s0_r <= s0_c;
        ca_r <= ca_c;
        cb_r <= cb_c;
      end
      S_X1:   x1_r <= x1_c;
      S_X2:   x2_r <= x2_c;
      S_X3:   x3_r <= x3_c;
      S_GAIN: m_r  <= m_c;
      S_PAN: begin
        res_left_r  <= sat16(pl_c[PL_W-1:32]);
        res_right_r <= sat16(pr_c[PL_W-1:32]);
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/wco_checker.sv -----
// Port-level checker for the wavetable oscillator core, bound to the core module.
`include "assert_macros.svh"

module wco_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_mode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [wco_pkg::SAMPLE_W-1:0] out_left_sample,
  input logic signed [wco_pkg::SAMPLE_W-1:0] out_right_sample
);

  import wco_pkg::*;

  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_left_sample) && $stable(out_right_sample), "stalled output item changed")

  `CHK_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && in_ready, "reset left output valid or input blocked")

  `CHK_ASSERT(a_write_no_item, clk, rst_n, in_valid && in_ready && (in_mode == MODE_WRITE) && !out_valid |=> !out_valid, "table write produced an output item")

  `CHK_ASSERT(a_tick_busy, clk, rst_n, in_valid && in_ready && (in_mode == MODE_TICK) |=> !in_ready, "input taken while a tick is in flight")

endmodule

bind wavetable_cubic_oscillator_core wco_checker u_wco_checker (.*);
